// ===== hw/rtl/cbs_pkg.sv =====
// Shared types and constants for the centered boxcar smoother.
// No dependencies; imported by the channel interfaces, cbs_front, cbs_back and the top unit.
package cbs_pkg;

   localparam int SAMPLE_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// ===== hw/rtl/cbs_req_if.sv =====
// Input channel of the smoother: one sample word with its last-sample flag.
// Depends on cbs_pkg.
interface cbs_req_if import cbs_pkg::*; ();

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       final_sample;

   modport source (output valid, output sample, output final_sample, input ready);
   modport sink   (input valid, input sample, input final_sample, output ready);

endinterface

// ===== hw/rtl/cbs_rsp_if.sv =====
// Result channel of the smoother: one smoothed word with its end-of-run flag.
// Depends on cbs_pkg.
interface cbs_rsp_if import cbs_pkg::*; ();

   logic       valid;
   logic       ready;
   sample_type smoothed;
   logic       end_of_run;

   modport source (output valid, output smoothed, output end_of_run, input ready);
   modport sink   (input valid, input smoothed, input end_of_run, output ready);

endinterface

// ===== hw/rtl/cbs_front.sv =====
// Front end: takes sample words, keeps the delay line and running sum, and turns
// words that yield output into back-end commands. Depends on cbs_pkg, cbs_req_if.
module cbs_front import cbs_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic   clock,
   input  logic   reset,
   cbs_req_if.sink req,
   output logic   cmd_valid,
   input  logic   cmd_ready,
   output logic [((WINDOW-1)/2)*SAMPLE_W + SAMPLE_W + $clog2(WINDOW)
                 + $clog2((WINDOW-1)/2 + 1) + 1 : 0] cmd_data
);

   localparam int HALF   = (WINDOW - 1) / 2;
   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SUM_W  = SAMPLE_W + LOG_W;
   localparam int SEEN_W = $clog2(WINDOW + 1);
   localparam int RCNT_W = $clog2(HALF + 1);

   sample_type                dl_ff [WINDOW];
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SEEN_W-1:0]         seen_ff, seen_in;

   logic                      accept;
   logic                      full_window;
   logic                      has_mean;
   logic [RCNT_W-1:0]         raw_cnt;
   logic [SEEN_W-1:0]         fill_cnt;
   logic [HALF-1:0][SAMPLE_W-1:0] raw;

   assign req.ready   = cmd_ready;
   assign accept      = req.valid && req.ready;
   assign full_window = (seen_ff >= SEEN_W'(WINDOW));
   assign has_mean    = (seen_ff >= SEEN_W'(WINDOW - 1));
   // raw words flushed by a short run: everything past the leading edge
   assign fill_cnt    = seen_ff - SEEN_W'(HALF - 1);

   always_comb begin
      sum_in = sum_ff + SUM_W'(req.sample)
               - (full_window ? SUM_W'(dl_ff[WINDOW-1]) : SUM_W'(0));
      if (req.final_sample) begin
         seen_in = '0;
      end else if (seen_ff < SEEN_W'(WINDOW)) begin
         seen_in = seen_ff + 1'b1;
      end else begin
         seen_in = seen_ff;
      end
   end

   always_comb begin
      if (seen_ff < SEEN_W'(HALF)) begin
         raw_cnt = RCNT_W'(1);
      end else if (!has_mean) begin
         raw_cnt = req.final_sample ? fill_cnt[RCNT_W-1:0] : '0;
      end else begin
         raw_cnt = req.final_sample ? RCNT_W'(HALF) : '0;
      end
   end

   // newest HALF entries of the delay line after this word shifts in
   always_comb begin
      raw[0] = req.sample;
      for (int k = 1; k < HALF; k++) begin
         raw[k] = dl_ff[k-1];
      end
   end

   assign cmd_valid = accept && (has_mean || (raw_cnt != '0));
   assign cmd_data  = {has_mean, req.final_sample, raw_cnt, sum_in, raw};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         seen_ff <= '0;
      end else if (accept) begin
         sum_ff  <= req.final_sample ? SUM_W'(0) : sum_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dl_ff[0] <= req.sample;
         for (int k = 1; k < WINDOW; k++) begin
            dl_ff[k] <= dl_ff[k-1];
         end
      end
   end

endmodule

// ===== hw/rtl/cbs_queue.sv =====
// Short command queue between the front and back ends.
// No dependencies.
module cbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== hw/rtl/cbs_back.sv =====
// Back end: expands each command into result words, divides window sums by
// the window width, and drives the result channel. Depends on cbs_pkg, cbs_rsp_if.
module cbs_back import cbs_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   cmd_valid,
   output logic   cmd_ready,
   input  logic [((WINDOW-1)/2)*SAMPLE_W + SAMPLE_W + $clog2(WINDOW)
                 + $clog2((WINDOW-1)/2 + 1) + 1 : 0] cmd_data,
   cbs_rsp_if.source rsp
);

   localparam int HALF    = (WINDOW - 1) / 2;
   localparam int LOG_W   = $clog2(WINDOW);
   localparam int SUM_W   = SAMPLE_W + LOG_W;
   localparam int MAG_W   = SUM_W - 1;
   localparam int RCNT_W  = $clog2(HALF + 1);
   localparam int RIDX_W  = (HALF > 1) ? $clog2(HALF) : 1;
   // |sum| * RECIP >> SHIFT is the exact quotient for every |sum| below 2**MAG_W
   localparam int SHIFT   = MAG_W + LOG_W;
   localparam int RECIP_W = MAG_W + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam longint unsigned RecipFull =
      ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RecipFull);

   logic                          cmd_mean;
   logic                          cmd_fin;
   logic [RCNT_W-1:0]             cmd_cnt;
   logic signed [SUM_W-1:0]       cmd_sum;
   logic [HALF-1:0][SAMPLE_W-1:0] cmd_raw;

   logic                  mean_done_ff;
   logic [RCNT_W-1:0]     raw_done_ff;
   logic                  adv, issue, mean_pend, last_of_cmd;
   logic [RCNT_W-1:0]     raw_left, raw_pos;
   logic [RIDX_W-1:0]     raw_sel;
   logic                  elem_end;

   logic                  s1_valid_ff, s1_mean_ff, s1_neg_ff, s1_end_ff;
   logic [MAG_W-1:0]      s1_mag_ff;
   sample_type            s1_raw_ff;
   logic                  s2_valid_ff, s2_mean_ff, s2_neg_ff, s2_end_ff;
   logic [PROD_W-1:0]     s2_prod_ff;
   sample_type            s2_raw_ff;
   logic                  out_valid_ff, out_end_ff;
   sample_type            out_val_ff, out_val_in;
   logic [SAMPLE_W-1:0]   quotient;

   assign {cmd_mean, cmd_fin, cmd_cnt, cmd_sum, cmd_raw} = cmd_data;

   // whole pipe moves when the output word is free or being taken
   assign adv       = !out_valid_ff || rsp.ready;
   assign issue     = cmd_valid && adv;
   assign mean_pend = cmd_mean && !mean_done_ff;
   assign raw_left  = cmd_cnt - raw_done_ff;
   assign raw_pos   = raw_left - 1'b1;
   assign raw_sel   = raw_pos[RIDX_W-1:0];

   always_comb begin
      if (mean_pend) begin
         last_of_cmd = (cmd_cnt == '0);
         elem_end    = 1'b0;
      end else begin
         last_of_cmd = (raw_left == RCNT_W'(1));
         elem_end    = cmd_fin && (raw_left == RCNT_W'(1));
      end
   end

   assign cmd_ready = issue && last_of_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_done_ff <= 1'b0;
         raw_done_ff  <= '0;
      end else if (issue) begin
         if (last_of_cmd) begin
            mean_done_ff <= 1'b0;
            raw_done_ff  <= '0;
         end else if (mean_pend) begin
            mean_done_ff <= 1'b1;
         end else begin
            raw_done_ff  <= raw_done_ff + 1'b1;
         end
      end
   end

   assign quotient   = s2_prod_ff[PROD_W-1:SHIFT];
   assign out_val_in = s2_mean_ff ? (s2_neg_ff ? sample_type'(-quotient)
                                               : sample_type'(quotient))
                                  : s2_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mean_ff <= mean_pend;
         s1_neg_ff  <= cmd_sum[SUM_W-1];
         s1_mag_ff  <= MAG_W'(cmd_sum[SUM_W-1] ? -cmd_sum : cmd_sum);
         s1_raw_ff  <= sample_type'(cmd_raw[raw_sel]);
         s1_end_ff  <= elem_end;

         s2_mean_ff <= s1_mean_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_prod_ff <= PROD_W'(s1_mag_ff) * PROD_W'(RECIP);
         s2_raw_ff  <= s1_raw_ff;
         s2_end_ff  <= s1_end_ff;

         out_val_ff <= out_val_in;
         out_end_ff <= s2_end_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.smoothed   = out_val_ff;
   assign rsp.end_of_run = out_end_ff;

endmodule

// ===== hw/rtl/centered_boxcar_smoother_unit.sv =====
// Centered boxcar smoother: each sample word is replaced by the mean of the
// WINDOW words centered on it (truncated toward zero); the first and last
// (WINDOW-1)/2 words of a run, and every word of a run shorter than WINDOW,
// pass through raw. A new word is accepted every cycle while the two-entry
// command queue has room. A word normally yields zero or one result word;
// the last word of a run yields up to (WINDOW+1)/2, which the back end emits
// one per cycle while the result channel is not stalled, so such a word holds
// the back end until all of them are issued. Results pass through the expand
// stage, the multiply by the reciprocal of WINDOW and the output register.
// Depends on cbs_pkg, cbs_req_if, cbs_rsp_if, cbs_front, cbs_queue, cbs_back.
module centered_boxcar_smoother_unit import cbs_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   cbs_req_if.sink     req_chan,
   cbs_rsp_if.source   rsp_chan
);

   localparam int HALF   = (WINDOW - 1) / 2;
   localparam int CMD_W  = HALF * SAMPLE_W + SAMPLE_W + $clog2(WINDOW)
                           + $clog2(HALF + 1) + 2;

   logic             push_valid, push_ready;
   logic [CMD_W-1:0] push_data;
   logic             pop_valid, pop_ready;
   logic [CMD_W-1:0] pop_data;

   cbs_front #(.WINDOW(WINDOW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_data  (push_data)
   );

   cbs_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   cbs_back #(.WINDOW(WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .rsp       (rsp_chan)
   );

endmodule
